>>> rtl/hnm_pkg.sv
// hnm_pkg: shared types and constants of the height-to-normal-map block.
// Used by every module of the block except hnm_ram; depends on nothing.
package hnm_pkg;

    localparam int HEIGHT_BITS = 16;
    localparam int DIM_CFG_W   = 9;
    localparam int SCALE_W     = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int BYTE_W      = 8;
    localparam int DIFF_W      = HEIGHT_BITS + 1;
    localparam int SQRT_STEPS  = 31;
    localparam int DIV_STEPS   = 9;

    typedef logic [0:0] t_cfg_idx;
    localparam t_cfg_idx CFG_DIMENSION    = 1'b0;
    localparam t_cfg_idx CFG_RELIEF_SCALE = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE, S_RD_XL, S_RD_X, S_RD_C, S_WR, S_START, S_WAIT, S_PUSH, S_FIN
    } t_state;

    // which texel of the up to four emitted for one sample
    typedef enum logic [1:0] {
        EM_INNER, EM_ROW_END, EM_LAST_ROW, EM_CORNER
    } t_emit;

    typedef enum logic [3:0] {
        NP_IDLE, NP_MUL, NP_SHIFT, NP_SQ, NP_SUM, NP_SQRT, NP_NUM, NP_DIV, NP_DONE
    } t_norm_phase;

    typedef struct packed {
        logic  latch_h;
        logic  cap_xl;
        logic  cap_x;
        logic  cap_c;
        logic  wr;
        logic  bank;      // bank holding the row above
        logic  norm_start;
        t_emit emit;
        logic  row_gt1;
        logic  push;
        logic  run_last;
        logic  fin;
    } t_cmd;

    typedef struct packed {
        logic norm_done;
        logic out_free;
    } t_status;

endpackage

>>> rtl/hnm_if.sv
// hnm_in_if / hnm_out_if: valid/ready channels of the block.
// Depends on hnm_pkg for field widths.
interface hnm_in_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [hnm_pkg::HEIGHT_BITS-1:0]   height_sample;
    modport source (output valid, output height_sample, input ready);
    modport sink   (input valid, input height_sample, output ready);
endinterface

interface hnm_out_if;
    logic                         valid;
    logic                         ready;
    logic [hnm_pkg::BYTE_W-1:0]   normal_x;
    logic [hnm_pkg::BYTE_W-1:0]   normal_y;
    logic [hnm_pkg::BYTE_W-1:0]   normal_z;
    logic [hnm_pkg::BYTE_W-1:0]   texel_column;
    logic [hnm_pkg::BYTE_W-1:0]   texel_row;
    logic                         run_last;
    modport source (output valid, output normal_x, output normal_y, output normal_z,
                    output texel_column, output texel_row, output run_last, input ready);
    modport sink   (input valid, input normal_x, input normal_y, input normal_z,
                    input texel_column, input texel_row, input run_last, output ready);
endinterface

>>> rtl/hnm_ram.sv
// hnm_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module hnm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/hnm_norm.sv
// hnm_norm: iterative normalizer, (gx, gy, 1) scaled and normalized to bytes.
// Depends on hnm_pkg. Multiply, shift, square, bit-serial sqrt, bit-serial divide.
module hnm_norm (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    input  logic signed [hnm_pkg::DIFF_W-1:0]      i_dx,
    input  logic signed [hnm_pkg::DIFF_W-1:0]      i_dy,
    input  logic [hnm_pkg::SCALE_W-1:0]            i_scale,
    output logic                                   o_done,
    output logic [hnm_pkg::BYTE_W-1:0]             o_nx,
    output logic [hnm_pkg::BYTE_W-1:0]             o_ny,
    output logic [hnm_pkg::BYTE_W-1:0]             o_nz
);
    hnm_pkg::t_norm_phase r_phase, n_phase;
    logic signed [33:0] r_gx, r_gy;
    logic [29:0]        r_mag [3];
    logic               r_sx, r_sy;
    logic [61:0]        r_mz2;
    logic [59:0]        r_sqx, r_sqy;
    logic [61:0]        r_s, r_root, r_bit;
    logic [4:0]         r_cnt;
    logic [40:0]        r_rem [3];
    logic [40:0]        r_dsh;
    logic [8:0]         r_q [3];

    logic [33:0]        abs_x, abs_y;
    logic [1:0]         k;
    logic [62:0]        trial;
    logic [30:0]        len;
    logic signed [40:0] comp [3];
    logic signed [40:0] num [3];
    logic [8:0]         q_sat [3];

    always_comb begin
        abs_x = r_gx[33] ? 34'(-r_gx) : 34'(r_gx);
        abs_y = r_gy[33] ? 34'(-r_gy) : 34'(r_gy);
        if (abs_x[31] || abs_y[31]) begin
            k = 2'd2;
        end else if (abs_x[30] || abs_y[30]) begin
            k = 2'd1;
        end else begin
            k = 2'd0;
        end
        trial = {1'b0, r_root} + {1'b0, r_bit};
        len   = r_root[30:0];
        comp[0] = r_sx ? -$signed({11'b0, r_mag[0]}) : $signed({11'b0, r_mag[0]});
        comp[1] = r_sy ? -$signed({11'b0, r_mag[1]}) : $signed({11'b0, r_mag[1]});
        comp[2] = $signed({11'b0, r_mag[2]});
        for (int j = 0; j < 3; j++) begin
            // 255*c + 256*L
            num[j]   = (comp[j] <<< 8) - comp[j] + $signed({2'b0, len, 8'b0});
            q_sat[j] = r_q[j];
        end
    end

    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            hnm_pkg::NP_IDLE:  if (i_start) n_phase = hnm_pkg::NP_MUL;
            hnm_pkg::NP_MUL:   n_phase = hnm_pkg::NP_SHIFT;
            hnm_pkg::NP_SHIFT: n_phase = hnm_pkg::NP_SQ;
            hnm_pkg::NP_SQ:    n_phase = hnm_pkg::NP_SUM;
            hnm_pkg::NP_SUM:   n_phase = hnm_pkg::NP_SQRT;
            hnm_pkg::NP_SQRT:
                if (r_cnt == 5'(hnm_pkg::SQRT_STEPS - 1)) n_phase = hnm_pkg::NP_NUM;
            hnm_pkg::NP_NUM:   n_phase = hnm_pkg::NP_DIV;
            hnm_pkg::NP_DIV:
                if (r_cnt == 5'(hnm_pkg::DIV_STEPS - 1)) n_phase = hnm_pkg::NP_DONE;
            hnm_pkg::NP_DONE:  n_phase = hnm_pkg::NP_IDLE;
            default:           n_phase = hnm_pkg::NP_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= hnm_pkg::NP_IDLE;
        end else begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_phase)
            hnm_pkg::NP_MUL: begin
                r_gx <= 34'(i_dx * $signed({1'b0, i_scale}));
                r_gy <= 34'(i_dy * $signed({1'b0, i_scale}));
            end
            hnm_pkg::NP_SHIFT: begin
                r_sx     <= r_gx[33];
                r_sy     <= r_gy[33];
                r_mag[0] <= 30'(abs_x >> k);
                r_mag[1] <= 30'(abs_y >> k);
                r_mag[2] <= 30'(21'h100000 >> k);
                r_mz2    <= 62'(1) << (6'd40 - {3'b0, k, 1'b0});
            end
            hnm_pkg::NP_SQ: begin
                r_sqx <= r_mag[0] * r_mag[0];
                r_sqy <= r_mag[1] * r_mag[1];
            end
            hnm_pkg::NP_SUM: begin
                r_s    <= 62'(r_sqx) + 62'(r_sqy) + r_mz2;
                r_root <= '0;
                r_bit  <= 62'(1) << 60;
                r_cnt  <= '0;
            end
            hnm_pkg::NP_SQRT: begin
                if ({1'b0, r_s} >= trial) begin
                    r_s    <= r_s - trial[61:0];
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
                r_cnt <= r_cnt + 5'd1;
            end
            hnm_pkg::NP_NUM: begin
                for (int j = 0; j < 3; j++) begin
                    r_rem[j] <= num[j][40] ? '0 : 41'(num[j]);
                    r_q[j]   <= '0;
                end
                r_dsh <= {1'b0, len, 9'b0};
                r_cnt <= '0;
            end
            hnm_pkg::NP_DIV: begin
                for (int j = 0; j < 3; j++) begin
                    if (r_rem[j] >= r_dsh) begin
                        r_rem[j] <= r_rem[j] - r_dsh;
                        r_q[j]   <= {r_q[j][7:0], 1'b1};
                    end else begin
                        r_q[j]   <= {r_q[j][7:0], 1'b0};
                    end
                end
                r_dsh <= r_dsh >> 1;
                r_cnt <= r_cnt + 5'd1;
            end
            default: begin
            end
        endcase
    end

    assign o_done = (r_phase == hnm_pkg::NP_DONE);
    assign o_nx   = q_sat[0][8] ? 8'hFF : q_sat[0][7:0];
    assign o_ny   = q_sat[1][8] ? 8'hFF : q_sat[1][7:0];
    assign o_nz   = q_sat[2][8] ? 8'hFF : q_sat[2][7:0];
endmodule

>>> rtl/hnm_datapath.sv
// hnm_datapath: line buffers, neighbor registers, normalizer and output word register.
// Depends on hnm_pkg, hnm_ram, hnm_norm and hnm_if.
module hnm_datapath #(
    parameter int MAX_DIM = 256
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  hnm_pkg::t_cmd                         i_cmd,
    output hnm_pkg::t_status                      o_status,
    input  logic [$clog2(MAX_DIM)-1:0]            i_addr,
    input  logic [$clog2(MAX_DIM)-1:0]            i_emit_col,
    input  logic [$clog2(MAX_DIM)-1:0]            i_emit_row,
    input  logic [hnm_pkg::SCALE_W-1:0]           i_scale,
    input  logic signed [hnm_pkg::HEIGHT_BITS-1:0] i_height,
    hnm_out_if.source                             o_normal
);
    localparam int AW = $clog2(MAX_DIM);
    localparam int HB = hnm_pkg::HEIGHT_BITS;

    logic [HB-1:0] rd0, rd1, above_q, cur_q;
    logic          we0, we1;
    logic signed [HB-1:0] r_h, r_a_xl, r_a_x, r_a_c, r_c_xl, r_c_x, r_c_old, r_down;
    logic signed [HB-1:0] hl, hr, hd, hu;
    logic signed [hnm_pkg::DIFF_W-1:0] dx, dy;
    logic          norm_done;
    logic [hnm_pkg::BYTE_W-1:0] nx, ny, nz;
    logic [AW+7:0] col_ext, row_ext;
    logic          r_ov;
    logic [hnm_pkg::BYTE_W-1:0] r_nx, r_ny, r_nz, r_col, r_row;
    logic          r_last;

    // bank select names the row above; the other bank takes the current row
    assign we0 = i_cmd.wr &&  i_cmd.bank;
    assign we1 = i_cmd.wr && !i_cmd.bank;

    hnm_ram #(.WIDTH(HB), .DEPTH(MAX_DIM)) u_ram0 (
        .i_clk(i_clk), .i_we(we0), .i_waddr(i_addr), .i_wdata(r_h),
        .i_raddr(i_addr), .o_rdata(rd0)
    );
    hnm_ram #(.WIDTH(HB), .DEPTH(MAX_DIM)) u_ram1 (
        .i_clk(i_clk), .i_we(we1), .i_waddr(i_addr), .i_wdata(r_h),
        .i_raddr(i_addr), .o_rdata(rd1)
    );

    assign above_q = i_cmd.bank ? rd1 : rd0;
    assign cur_q   = i_cmd.bank ? rd0 : rd1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_h) r_h <= i_height;
        if (i_cmd.cap_xl) begin
            r_a_xl <= above_q;
            r_c_xl <= cur_q;
        end
        if (i_cmd.cap_x) begin
            r_a_x <= above_q;
            r_c_x <= cur_q;
        end
        if (i_cmd.cap_c) begin
            r_a_c   <= above_q;
            r_c_old <= cur_q;
        end
        if (i_cmd.fin) r_down <= r_c_old;
    end

    always_comb begin
        unique case (i_cmd.emit)
            hnm_pkg::EM_INNER: begin
                hl = r_a_xl; hr = r_a_c;
                hd = i_cmd.row_gt1 ? r_down : r_a_x;
                hu = r_c_x;
            end
            hnm_pkg::EM_ROW_END: begin
                hl = r_a_x; hr = r_a_c;
                hd = i_cmd.row_gt1 ? r_c_old : r_a_c;
                hu = r_h;
            end
            hnm_pkg::EM_LAST_ROW: begin
                hl = r_c_xl; hr = r_h; hd = r_a_x; hu = r_c_x;
            end
            hnm_pkg::EM_CORNER: begin
                hl = r_c_x; hr = r_h; hd = r_a_c; hu = r_h;
            end
            default: begin
                hl = r_a_xl; hr = r_a_c; hd = r_a_x; hu = r_c_x;
            end
        endcase
        dx = hnm_pkg::DIFF_W'(hl) - hnm_pkg::DIFF_W'(hr);
        dy = hnm_pkg::DIFF_W'(hd) - hnm_pkg::DIFF_W'(hu);
    end

    hnm_norm u_norm (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.norm_start),
        .i_dx(dx), .i_dy(dy), .i_scale(i_scale),
        .o_done(norm_done), .o_nx(nx), .o_ny(ny), .o_nz(nz)
    );

    assign col_ext = {8'b0, i_emit_col};
    assign row_ext = {8'b0, i_emit_row};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.push) begin
            r_ov <= 1'b1;
        end else if (o_normal.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_nx   <= nx;
            r_ny   <= ny;
            r_nz   <= nz;
            r_col  <= col_ext[7:0];
            r_row  <= row_ext[7:0];
            r_last <= i_cmd.run_last;
        end
    end

    assign o_normal.valid        = r_ov;
    assign o_normal.normal_x     = r_nx;
    assign o_normal.normal_y     = r_ny;
    assign o_normal.normal_z     = r_nz;
    assign o_normal.texel_column = r_col;
    assign o_normal.texel_row    = r_row;
    assign o_normal.run_last     = r_last;

    assign o_status.norm_done = norm_done;
    assign o_status.out_free  = !r_ov || o_normal.ready;
endmodule

>>> rtl/hnm_ctrl.sv
// hnm_ctrl: sequencer, raster counters and configuration registers.
// Depends on hnm_pkg.
module hnm_ctrl #(
    parameter int MAX_DIM = 256
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_cfg_we,
    input  hnm_pkg::t_cfg_idx                  i_cfg_idx,
    input  logic [hnm_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  hnm_pkg::t_status                   i_status,
    output hnm_pkg::t_cmd                      o_cmd,
    output logic [$clog2(MAX_DIM)-1:0]         o_addr,
    output logic [$clog2(MAX_DIM)-1:0]         o_emit_col,
    output logic [$clog2(MAX_DIM)-1:0]         o_emit_row,
    output logic [hnm_pkg::SCALE_W-1:0]        o_scale
);
    localparam int AW        = $clog2(MAX_DIM);
    localparam int DW        = $clog2(MAX_DIM + 1);
    localparam int DIM_RESET = (64 > MAX_DIM) ? MAX_DIM : 64;

    hnm_pkg::t_state r_state, n_state;
    hnm_pkg::t_emit  r_emit, n_emit;
    logic [AW-1:0]   r_col, r_row, r_c, r_r;
    logic [DW-1:0]   r_dim;
    logic [hnm_pkg::SCALE_W-1:0] r_scale;
    logic            r_bank;

    logic [AW-1:0]   c_now, r_now, x, xl;
    logic [DW-1:0]   n_m1;
    logic            row_end, last_row, has_next, accept;
    logic [31:0]     dim_v;
    hnm_pkg::t_emit  next_emit;

    always_comb begin
        n_m1     = r_dim - DW'(1);
        c_now    = (DW'(r_col) >= r_dim) ? '0 : r_col;
        r_now    = (DW'(r_row) >= r_dim) ? '0 : r_row;
        x        = r_c - AW'(1);
        xl       = (32'(r_c) >= 32'd2) ? r_c - AW'(2) : r_c - AW'(1);
        row_end  = (DW'(r_c) == n_m1);
        last_row = (DW'(r_r) == n_m1);
        accept   = (r_state == hnm_pkg::S_IDLE) && i_in_valid;
        // emission order: inner, row end, last row, corner
        has_next  = 1'b0;
        next_emit = hnm_pkg::EM_INNER;
        unique case (r_emit)
            hnm_pkg::EM_INNER: begin
                if (row_end) begin
                    has_next = 1'b1; next_emit = hnm_pkg::EM_ROW_END;
                end else if (last_row) begin
                    has_next = 1'b1; next_emit = hnm_pkg::EM_LAST_ROW;
                end
            end
            hnm_pkg::EM_ROW_END: begin
                has_next = last_row; next_emit = hnm_pkg::EM_LAST_ROW;
            end
            hnm_pkg::EM_LAST_ROW: begin
                has_next = row_end; next_emit = hnm_pkg::EM_CORNER;
            end
            hnm_pkg::EM_CORNER: begin
                has_next = 1'b0;
            end
            default: has_next = 1'b0;
        endcase
        dim_v = 32'(i_cfg_data[hnm_pkg::DIM_CFG_W-1:0]);
        if (dim_v < 32'd2) dim_v = 32'd2;
        if (dim_v > 32'(MAX_DIM)) dim_v = 32'(MAX_DIM);
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_emit  = r_emit;
        unique case (r_state)
            hnm_pkg::S_IDLE:  if (i_in_valid) n_state = hnm_pkg::S_RD_XL;
            hnm_pkg::S_RD_XL: n_state = hnm_pkg::S_RD_X;
            hnm_pkg::S_RD_X:  n_state = hnm_pkg::S_RD_C;
            hnm_pkg::S_RD_C:  n_state = hnm_pkg::S_WR;
            hnm_pkg::S_WR: begin
                n_emit = hnm_pkg::EM_INNER;
                if (r_c != '0 && r_r != '0) begin
                    n_state = hnm_pkg::S_START;
                end else begin
                    n_state = hnm_pkg::S_FIN;
                end
            end
            hnm_pkg::S_START: n_state = hnm_pkg::S_WAIT;
            hnm_pkg::S_WAIT:  if (i_status.norm_done) n_state = hnm_pkg::S_PUSH;
            hnm_pkg::S_PUSH: begin
                if (i_status.out_free) begin
                    if (has_next) begin
                        n_state = hnm_pkg::S_START;
                        n_emit  = next_emit;
                    end else begin
                        n_state = hnm_pkg::S_FIN;
                    end
                end
            end
            hnm_pkg::S_FIN:   n_state = hnm_pkg::S_IDLE;
            default:          n_state = hnm_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd            = '0;
        o_cmd.bank       = r_bank;
        o_cmd.emit       = r_emit;
        o_cmd.row_gt1    = (32'(r_r) >= 32'd2);
        o_cmd.latch_h    = accept;
        o_addr           = r_c;
        o_emit_col       = x;
        o_emit_row       = r_r - AW'(1);
        unique case (r_state)
            hnm_pkg::S_RD_XL: o_addr = xl;
            hnm_pkg::S_RD_X: begin
                o_addr       = x;
                o_cmd.cap_xl = 1'b1;
            end
            hnm_pkg::S_RD_C: begin
                o_addr      = r_c;
                o_cmd.cap_x = 1'b1;
            end
            hnm_pkg::S_WR: begin
                o_cmd.cap_c = 1'b1;
                o_cmd.wr    = 1'b1;
            end
            hnm_pkg::S_START: o_cmd.norm_start = 1'b1;
            hnm_pkg::S_PUSH: begin
                o_cmd.push     = i_status.out_free;
                o_cmd.run_last = !has_next;
            end
            hnm_pkg::S_FIN: o_cmd.fin = 1'b1;
            default: begin
            end
        endcase
        if (r_emit == hnm_pkg::EM_ROW_END || r_emit == hnm_pkg::EM_CORNER) begin
            o_emit_col = r_c;
        end
        if (r_emit == hnm_pkg::EM_LAST_ROW || r_emit == hnm_pkg::EM_CORNER) begin
            o_emit_row = r_r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hnm_pkg::S_IDLE;
            r_emit  <= hnm_pkg::EM_INNER;
            r_col   <= '0;
            r_row   <= '0;
            r_bank  <= 1'b0;
            r_dim   <= DW'(DIM_RESET);
            r_scale <= hnm_pkg::SCALE_W'(328);
        end else begin
            r_state <= n_state;
            r_emit  <= n_emit;
            if (r_state == hnm_pkg::S_FIN) begin
                if (row_end) begin
                    r_col  <= '0;
                    r_row  <= last_row ? '0 : r_r + AW'(1);
                    r_bank <= !r_bank;
                end else begin
                    r_col <= r_c + AW'(1);
                    r_row <= r_r;
                end
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    hnm_pkg::CFG_DIMENSION: begin
                        r_dim <= DW'(dim_v);
                        r_col <= '0;
                        r_row <= '0;
                    end
                    hnm_pkg::CFG_RELIEF_SCALE: r_scale <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_c <= c_now;
            r_r <= r_now;
        end
    end

    assign o_in_ready = (r_state == hnm_pkg::S_IDLE);
    assign o_scale    = r_scale;
endmodule

>>> rtl/height_to_normal_map_core.sv
// height_to_normal_map_core: top level of the heightmap-to-normal-map baker.
// Depends on hnm_pkg, hnm_if, hnm_ctrl, hnm_datapath (and below them hnm_norm, hnm_ram).
//
// Usage:
//   i_height carries signed Q3.12 height samples of a square field in raster
//   order. o_normal carries tangent-space normal texels (x, y, z bytes), the
//   texel column and row, and run_last on the final word caused by a sample.
//   Each sample causes zero to four words: row 0 and column 0 cause none.
//   Configuration (dimension, relief_scale) is written through i_cfg_we /
//   i_cfg_idx / i_cfg_data while the block is idle; a dimension write
//   restarts the raster counters.
// Sequencing:
//   One sample at a time. For a sample with no words, ready rises again after
//   the sequencer has gone through S_RD_XL, S_RD_X, S_RD_C, S_WR and S_FIN.
//   Each word adds a normalizer run (multiply, shift, square, bit-serial square
//   root, bit-serial divide) and any wait for a free output. Two line-buffer
//   RAMs are read at three addresses per sample.
// Reset and stall:
//   Synchronous reset sets dimension 64, relief_scale 328 and counters to the
//   origin. The output word register holds while o_normal.ready is low; the
//   sequencer waits for it before pushing the next word, and the next sample
//   is accepted while the last word of a sample still waits.
module height_to_normal_map_core #(
    parameter int MAX_DIM = 256
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    hnm_in_if.sink                             i_height,
    hnm_out_if.source                          o_normal,
    input  logic                               i_cfg_we,
    input  hnm_pkg::t_cfg_idx                  i_cfg_idx,
    input  logic [hnm_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    localparam int AW = $clog2(MAX_DIM);

    hnm_pkg::t_cmd    cmd;
    hnm_pkg::t_status status;
    logic [AW-1:0]    addr, emit_col, emit_row;
    logic [hnm_pkg::SCALE_W-1:0] scale;
    logic             in_ready;

    hnm_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_height.valid), .o_in_ready(in_ready),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_status(status), .o_cmd(cmd), .o_addr(addr),
        .o_emit_col(emit_col), .o_emit_row(emit_row), .o_scale(scale)
    );

    assign i_height.ready = in_ready;

    hnm_datapath #(.MAX_DIM(MAX_DIM)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_status(status),
        .i_addr(addr), .i_emit_col(emit_col), .i_emit_row(emit_row),
        .i_scale(scale), .i_height(i_height.height_sample), .o_normal(o_normal)
    );

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_height.valid && in_ready) |=> !in_ready)
        else $error("sample accepted while previous one in flight");

    a_push_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.push |-> status.out_free)
        else $error("word pushed over a held output word");

    a_no_write_while_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.wr |-> (!cmd.norm_start && !cmd.push))
        else $error("buffer write overlaps emission");

    a_done_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.norm_start |=> !status.norm_done)
        else $error("normalizer finished without working");
endmodule

>>> dv/hnm_checker.sv
// hnm_checker: watches the height and normal channels and the config port of
// height_to_normal_map_core, predicts every normal word and compares in order.
// Depends on hnm_pkg and the hnm_in_if / hnm_out_if interfaces.
module hnm_checker #(
    parameter int MAX_DIM = 256
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    hnm_in_if                              i_height,
    hnm_out_if                             i_normal,
    input  logic                           i_cfg_we,
    input  hnm_pkg::t_cfg_idx              i_cfg_idx,
    input  logic [hnm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending
);
    typedef struct {
        logic [7:0] nx;
        logic [7:0] ny;
        logic [7:0] nz;
        logic [7:0] col;
        logic [7:0] row;
        logic       last;
    } t_texel;

    t_texel texel_q[$];

    int     line_buf[2][MAX_DIM];
    bit     above_bank;
    int     col_cnt;
    int     row_cnt;
    int     down_hold;
    int     side;
    longint relief;

    assign o_pending = texel_q.size();

    function automatic longint unsigned root64(longint unsigned s);
        longint unsigned rt;
        longint unsigned b;
        rt = 0;
        b  = 64'd1 << 62;
        while (b > s) b = b >> 2;
        while (b != 0) begin
            if (s >= rt + b) begin
                s  = s - (rt + b);
                rt = (rt >> 1) + b;
            end else begin
                rt = rt >> 1;
            end
            b = b >> 2;
        end
        return rt;
    endfunction

    function automatic logic [7:0] comp_byte(longint c, longint len);
        longint num;
        longint b;
        num = 255 * c + 256 * len;
        if (num < 0) num = 0;
        b = num / (2 * len);
        return (b > 255) ? 8'd255 : b[7:0];
    endfunction

    function automatic t_texel bake(int hl, int hr, int hd, int hu, int col, int row,
                                    longint scale);
        longint          gx;
        longint          gy;
        longint unsigned mx;
        longint unsigned my;
        longint unsigned mz;
        longint          len;
        int              sh;
        t_texel          t;
        gx = (longint'(hl) - longint'(hr)) * scale;
        gy = (longint'(hd) - longint'(hu)) * scale;
        mx = (gx < 0) ? -gx : gx;
        my = (gy < 0) ? -gy : gy;
        sh = 0;
        while ((mx >> sh) >= (64'd1 << 30) || (my >> sh) >= (64'd1 << 30)) sh++;
        mx  = mx >> sh;
        my  = my >> sh;
        mz  = (64'd1 << 20) >> sh;
        len = root64(mx * mx + my * my + mz * mz);
        if (len < 1) len = 1;
        t.nx   = comp_byte((gx < 0) ? -longint'(mx) : longint'(mx), len);
        t.ny   = comp_byte((gy < 0) ? -longint'(my) : longint'(my), len);
        t.nz   = comp_byte(longint'(mz), len);
        t.col  = col[7:0];
        t.row  = row[7:0];
        t.last = 1'b0;
        return t;
    endfunction

    task automatic absorb_sample(int h);
        int     c;
        int     r;
        int     x;
        int     y;
        int     xl;
        int     old;
        int     hd;
        bit     cb;
        t_texel w[$];
        c  = (col_cnt >= side) ? 0 : col_cnt;
        r  = (row_cnt >= side) ? 0 : row_cnt;
        cb = ~above_bank;
        old = line_buf[cb][c];
        line_buf[cb][c] = h;
        if (r >= 1 && c >= 1) begin
            x  = c - 1;
            y  = r - 1;
            xl = (c >= 2) ? c - 2 : c - 1;
            hd = (y > 0) ? down_hold : line_buf[above_bank][x];
            w = {w, bake(line_buf[above_bank][xl], line_buf[above_bank][c], hd,
                         line_buf[cb][x], x, y, relief)};
            if (c == side - 1) begin
                hd = (y > 0) ? old : line_buf[above_bank][c];
                w = {w, bake(line_buf[above_bank][c-1], line_buf[above_bank][c], hd,
                             h, c, y, relief)};
            end
            if (r == side - 1) begin
                w = {w, bake(line_buf[cb][xl], h, line_buf[above_bank][x],
                             line_buf[cb][x], x, r, relief)};
                if (c == side - 1)
                    w = {w, bake(line_buf[cb][c-1], h, line_buf[above_bank][c], h,
                                 c, r, relief)};
            end
            w[w.size()-1].last = 1'b1;
            foreach (w[i]) texel_q = {texel_q, w[i]};
        end
        down_hold = old;
        c++;
        if (c >= side) begin
            c = 0;
            above_bank = ~above_bank;
            r++;
            if (r >= side) r = 0;
        end
        col_cnt = c;
        row_cnt = r;
    endtask

    always @(posedge i_clk) begin
        t_texel e;
        int     v;
        if (!i_rst_n) begin
            texel_q.delete();
            above_bank = 1'b0;
            col_cnt    = 0;
            row_cnt    = 0;
            down_hold  = 0;
            side       = 64;
            relief     = 328;
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == hnm_pkg::CFG_DIMENSION) begin
                    v = int'(i_cfg_data[hnm_pkg::DIM_CFG_W-1:0]);
                    side    = (v < 2) ? 2 : (v > MAX_DIM) ? MAX_DIM : v;
                    col_cnt = 0;
                    row_cnt = 0;
                end else if (i_cfg_idx == hnm_pkg::CFG_RELIEF_SCALE) begin
                    relief = longint'(i_cfg_data[hnm_pkg::SCALE_W-1:0]);
                end
            end
            if (i_height.valid && i_height.ready)
                absorb_sample(int'(i_height.height_sample));
            if (i_normal.valid && i_normal.ready) begin
                if (texel_q.size() == 0) begin
                    $error("unexpected normal word col=%0d row=%0d",
                           i_normal.texel_column, i_normal.texel_row);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    e = texel_q.pop_front();
                    if (e.nx !== i_normal.normal_x || e.ny !== i_normal.normal_y ||
                        e.nz !== i_normal.normal_z || e.col !== i_normal.texel_column ||
                        e.row !== i_normal.texel_row || e.last !== i_normal.run_last) begin
                        if (e.nx !== i_normal.normal_x)
                            $error("normal_x exp %0d got %0d", e.nx, i_normal.normal_x);
                        if (e.ny !== i_normal.normal_y)
                            $error("normal_y exp %0d got %0d", e.ny, i_normal.normal_y);
                        if (e.nz !== i_normal.normal_z)
                            $error("normal_z exp %0d got %0d", e.nz, i_normal.normal_z);
                        if (e.col !== i_normal.texel_column)
                            $error("texel_column exp %0d got %0d", e.col,
                                   i_normal.texel_column);
                        if (e.row !== i_normal.texel_row)
                            $error("texel_row exp %0d got %0d", e.row, i_normal.texel_row);
                        if (e.last !== i_normal.run_last)
                            $error("run_last exp %0d got %0d", e.last, i_normal.run_last);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

>>> dv/height_to_normal_map_core_tb.sv
// height_to_normal_map_core_tb: drives height samples and config writes into
// height_to_normal_map_core, varies backpressure, and reports the verdict.
// Depends on hnm_pkg, hnm_if, the core RTL and hnm_checker.
module height_to_normal_map_core_tb;
    localparam int LIMIT = 600000;
    localparam int HB    = hnm_pkg::HEIGHT_BITS;
    localparam int CW    = hnm_pkg::CFG_DATA_W;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    hnm_pkg::t_cfg_idx     cfg_idx;
    logic [CW-1:0]         cfg_data;
    int                    fail_count;
    int                    pending;
    int                    cycles;
    int                    tx_idle;
    int                    rx_idle;
    bit                    pressure_req;
    int                    hold_left;
    bit                    hold_used;

    hnm_in_if  height_ch ();
    hnm_out_if normal_ch ();

    height_to_normal_map_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_height   (height_ch),
        .o_normal   (normal_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    hnm_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_height     (height_ch),
        .i_normal     (normal_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // receiver: random stalls plus one long hold-off, started by an accepted
    // sample so the sender keeps offering words while the block backs up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            normal_ch.ready <= 1'b0;
        end else begin
            if (pressure_req && !hold_used && height_ch.valid && height_ch.ready) begin
                hold_used = 1'b1;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                normal_ch.ready <= 1'b0;
            end else begin
                normal_ch.ready <= ($urandom_range(99) >= rx_idle);
            end
        end
    end

    task automatic send_word(logic signed [HB-1:0] h);
        while ($urandom_range(99) < tx_idle) begin
            height_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        height_ch.valid         <= 1'b1;
        height_ch.height_sample <= h;
        do @(negedge i_clk); while (!height_ch.ready);
        @(posedge i_clk);
    endtask

    task automatic write_cfg(hnm_pkg::t_cfg_idx idx, logic [CW-1:0] data);
        height_ch.valid <= 1'b0;
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        height_ch.valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic random_phase(int dim, int scale, int count);
        drain();
        write_cfg(hnm_pkg::CFG_DIMENSION, CW'(dim));
        write_cfg(hnm_pkg::CFG_RELIEF_SCALE, CW'(scale));
        for (int i = 0; i < count; i++) begin
            // mostly smooth terrain, sometimes full-range spikes
            if ($urandom_range(3) == 0) send_word(HB'($urandom));
            else send_word(HB'($urandom_range(0, 4095) - 2048));
        end
    endtask

    initial begin
        logic signed [HB-1:0] corners[4];
        logic signed [HB-1:0] nine[9];
        corners = '{16'sh8000, 16'sh7fff, 16'sh0000, -16'sd1};
        nine    = '{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh0000,
                    16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff};
        hold_left = 0;
        hold_used = 1'b0;
        pressure_req = 1'b0;
        tx_idle  = 23;
        rx_idle  = 82;
        i_rst_n  = 1'b0;
        cfg_we   = 1'b0;
        cfg_idx  = hnm_pkg::CFG_DIMENSION;
        cfg_data = '0;
        height_ch.valid         = 1'b0;
        height_ch.height_sample = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: default, 2x2 full scale, 3x3 zero scale, then size 1
        foreach (corners[i]) send_word(corners[i]);
        drain();
        write_cfg(hnm_pkg::CFG_DIMENSION, CW'(0));        // clamps up to 2
        write_cfg(hnm_pkg::CFG_RELIEF_SCALE, 16'hffff);
        foreach (corners[i]) send_word(corners[i]);
        drain();
        write_cfg(hnm_pkg::CFG_DIMENSION, CW'(3));
        write_cfg(hnm_pkg::CFG_RELIEF_SCALE, CW'(0));
        foreach (nine[i]) send_word(nine[i]);
        drain();
        write_cfg(hnm_pkg::CFG_DIMENSION, CW'(1));
        write_cfg(hnm_pkg::CFG_RELIEF_SCALE, CW'(1));
        foreach (corners[i]) send_word(corners[i]);

        random_phase(4, $urandom_range(0, 65535), 16);
        pressure_req = 1'b1;
        random_phase(5, 328, 22);
        tx_idle = 82;
        rx_idle = 23;
        random_phase(511, 16'hffff, 262);       // clamps to 256
        tx_idle = 0;
        rx_idle = 0;
        random_phase(7, $urandom_range(0, 65535), 49);

        height_ch.valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (150) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
